### design/assert_macros.svh
// assertion helpers for the rtl, included by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/imuodo_pkg.sv
package imuodo_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ITW = 5;
  localparam int CW = 40;
  localparam int ZW = 34;
  localparam int AW = 34;
  localparam int BW = 25;
  localparam int PW = AW + BW;
  localparam int ACCW = 60;
  localparam int POSW = 48;
  localparam int QW = 16;
  localparam int TSW = 48;
  localparam int CFGW = 24;
  localparam int IN_W = 128;
  localparam int OUT_W = 200;

  localparam logic [CFGW-1:0] MAX_INTERVAL_RST = 24'd1000000;
  localparam logic signed [CW-1:0] KINV = 40'sd652032874;
  localparam logic signed [ACCW-1:0] POS_MAX = 60'sd140737488355327;
  localparam logic signed [ACCW-1:0] POS_MIN = -60'sd140737488355328;

  // multiply sequence codes
  localparam logic [ITW-1:0] MUL_WW = 5'd0;
  localparam logic [ITW-1:0] MUL_XX = 5'd1;
  localparam logic [ITW-1:0] MUL_YY = 5'd2;
  localparam logic [ITW-1:0] MUL_ZZ = 5'd3;
  localparam logic [ITW-1:0] MUL_XY = 5'd4;
  localparam logic [ITW-1:0] MUL_WZ = 5'd5;
  localparam logic [ITW-1:0] MUL_VX = 5'd6;
  localparam logic [ITW-1:0] MUL_VY = 5'd7;
  localparam logic [ITW-1:0] MUL_OX_A = 5'd8;
  localparam logic [ITW-1:0] MUL_OX_B = 5'd9;
  localparam logic [ITW-1:0] MUL_OY_A = 5'd10;
  localparam logic [ITW-1:0] MUL_OY_B = 5'd11;
  localparam logic [ITW-1:0] MUL_OZ_A = 5'd12;
  localparam logic [ITW-1:0] MUL_OZ_B = 5'd13;
  localparam logic [ITW-1:0] MUL_OW_A = 5'd14;
  localparam logic [ITW-1:0] MUL_OW_B = 5'd15;
  localparam logic [ITW-1:0] MUL_PX = 5'd16;
  localparam logic [ITW-1:0] MUL_PY = 5'd17;

  typedef enum logic [1:0] {
    STAT_PUB, STAT_INVALID, STAT_FIRST, STAT_RANGE
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_YMUL, ST_YWAIT, ST_VINIT, ST_VITER, ST_YAWFIN,
    ST_RINIT_REL, ST_RITER_REL, ST_RFIN_REL, ST_RINIT_REF, ST_RITER_REF,
    ST_RFIN_REF, ST_QMUL, ST_QWAIT, ST_PMUL, ST_PWAIT, ST_PUB
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_VINIT, OP_VITER, OP_YAWFIN, OP_RINIT_REL,
    OP_RINIT_REF, OP_RITER, OP_RFIN_REL, OP_RFIN_REF, OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t         op;
    logic [ITW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic quat_zero;
  } dp_stat_t;

  function automatic logic [31:0] atan_entry(input logic [ITW-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // round half up from q30, saturate to 16 bits
  function automatic logic signed [QW-1:0] rnd16(input logic signed [ACCW-1:0] p);
    logic signed [ACCW-1:0] t;
    t = (p + 60'sd536870912) >>> 30;
    if (t > 60'sd32767) return 16'sh7fff;
    else if (t < -60'sd32768) return 16'sh8000;
    else return QW'(t);
  endfunction

endpackage

### design/imuodo_ctrl.sv
module imuodo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output imuodo_pkg::dp_cmd_t   cmd,
  input  imuodo_pkg::dp_stat_t  stat
);
  import imuodo_pkg::*;
`include "assert_macros.svh"

  state_t         state_r, state_nxt;
  logic [ITW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           pub_go;
  logic           it_last;
  logic           in_iter;
  logic           in_acc;

  assign it_last = (cnt_r == ITW'(CORDIC_STAGES - 1));
  assign pub_go = (state_r == ST_PUB) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = MUL_WW;
        if (in_tvalid) state_nxt = stat.quat_zero ? ST_PUB : ST_YMUL;
      end
      ST_YMUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_WZ) state_nxt = ST_YWAIT;
      end
      ST_YWAIT: state_nxt = ST_VINIT;
      ST_VINIT: begin
        cnt_nxt = '0;
        state_nxt = ST_VITER;
      end
      ST_VITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (it_last) state_nxt = ST_YAWFIN;
      end
      ST_YAWFIN: state_nxt = ST_RINIT_REL;
      ST_RINIT_REL: begin
        cnt_nxt = '0;
        state_nxt = ST_RITER_REL;
      end
      ST_RITER_REL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (it_last) state_nxt = ST_RFIN_REL;
      end
      ST_RFIN_REL: state_nxt = ST_RINIT_REF;
      ST_RINIT_REF: begin
        cnt_nxt = '0;
        state_nxt = ST_RITER_REF;
      end
      ST_RITER_REF: begin
        cnt_nxt = cnt_r + 1'b1;
        if (it_last) state_nxt = ST_RFIN_REF;
      end
      ST_RFIN_REF: begin
        cnt_nxt = MUL_VX;
        state_nxt = ST_QMUL;
      end
      ST_QMUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_OW_B) state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        cnt_nxt = MUL_PX;
        state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_PY) state_nxt = ST_PWAIT;
      end
      ST_PWAIT: state_nxt = ST_PUB;
      ST_PUB: if (pub_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.idx = cnt_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) cmd.op = OP_LOAD;
      ST_YMUL, ST_QMUL, ST_PMUL: cmd.op = OP_MUL;
      ST_VINIT: cmd.op = OP_VINIT;
      ST_VITER: cmd.op = OP_VITER;
      ST_YAWFIN: cmd.op = OP_YAWFIN;
      ST_RINIT_REL: cmd.op = OP_RINIT_REL;
      ST_RINIT_REF: cmd.op = OP_RINIT_REF;
      ST_RITER_REL, ST_RITER_REF: cmd.op = OP_RITER;
      ST_RFIN_REL: cmd.op = OP_RFIN_REL;
      ST_RFIN_REF: cmd.op = OP_RFIN_REF;
      ST_PUB: if (pub_go) cmd.op = OP_PUB;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (pub_go) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  assign in_iter = (state_r == ST_VITER) || (state_r == ST_RITER_REL) ||
                   (state_r == ST_RITER_REF);
  assign in_acc = in_tvalid && in_tready;

  `ASSERT_NEXT(a_pub_sets_valid, clk, rst_n, pub_go, out_valid_r, "publish without out valid")
  `ASSERT_ALWAYS(a_iter_bound, clk, rst_n, !in_iter || cnt_r < ITW'(CORDIC_STAGES), "cordic overrun")
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_r != ST_IDLE, "accept stalled")

endmodule

### design/imuodo_dp.sv
module imuodo_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [imuodo_pkg::IN_W-1:0]        in_tdata,
  input  logic                               cfg_valid,
  input  logic [imuodo_pkg::CFGW-1:0]        cfg_data,
  output logic [imuodo_pkg::OUT_W-1:0]       out_tdata,
  input  imuodo_pkg::dp_cmd_t                cmd,
  output imuodo_pkg::dp_stat_t               stat
);
  import imuodo_pkg::*;

  logic signed [QW-1:0]   qx_r, qy_r, qz_r, qw_r, sp_r;
  logic [TSW-1:0]         ts_r;
  logic signed [CW-1:0]   cx_r, cy_r, x_r, y_r;
  logic signed [ZW-1:0]   z_r;
  logic [QW-1:0]          rel_r;
  logic signed [AW-1:0]   c_r, s_r, hc_r, hs_r;
  logic signed [QW-1:0]   velx_r, vely_r, oqx_r, oqy_r, oqz_r, oqw_r;
  logic [CFGW-1:0]        dt_r;
  status_t                status_r;
  logic                   ref_valid_r, time_valid_r;
  logic [QW-1:0]          ref_yaw_r;
  logic [TSW-1:0]         last_r;
  logic signed [POSW-1:0] posx_r, posy_r;
  logic [CFGW-1:0]        max_r;
  logic signed [PW-1:0]   prod_r;
  logic                   mv_r;
  logic [ITW-1:0]         msel_r;
  logic signed [ACCW-1:0] acc_r;
  logic [OUT_W-1:0]       out_r;

  logic signed [AW-1:0]   a_op;
  logic signed [BW-1:0]   b_op;
  logic signed [ACCW-1:0] pe, sum_x, sum_y;
  logic signed [CW-1:0]   sx, sy;
  logic signed [ZW-1:0]   at;
  logic [31:0]            ang, ang_q, ang_h;
  logic [QW-1:0]          yaw_w, ref_w;
  logic [TSW:0]           diff;
  logic                   ts_le, ts_over;

  assign stat.quat_zero = (in_tdata[63:0] == 64'd0);

  // multiplier operand select
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.idx)
      MUL_WW: begin a_op = AW'(qw_r); b_op = BW'(qw_r); end
      MUL_XX: begin a_op = AW'(qx_r); b_op = BW'(qx_r); end
      MUL_YY: begin a_op = AW'(qy_r); b_op = BW'(qy_r); end
      MUL_ZZ: begin a_op = AW'(qz_r); b_op = BW'(qz_r); end
      MUL_XY: begin a_op = AW'(qx_r); b_op = BW'(qy_r); end
      MUL_WZ: begin a_op = AW'(qw_r); b_op = BW'(qz_r); end
      MUL_VX: begin a_op = c_r; b_op = BW'(sp_r); end
      MUL_VY: begin a_op = s_r; b_op = BW'(sp_r); end
      MUL_OX_A: begin a_op = hc_r; b_op = BW'(qx_r); end
      MUL_OX_B: begin a_op = hs_r; b_op = BW'(qy_r); end
      MUL_OY_A: begin a_op = hc_r; b_op = BW'(qy_r); end
      MUL_OY_B: begin a_op = hs_r; b_op = BW'(qx_r); end
      MUL_OZ_A: begin a_op = hc_r; b_op = BW'(qz_r); end
      MUL_OZ_B: begin a_op = hs_r; b_op = BW'(qw_r); end
      MUL_OW_A: begin a_op = hc_r; b_op = BW'(qw_r); end
      MUL_OW_B: begin a_op = hs_r; b_op = BW'(qz_r); end
      MUL_PX: begin a_op = AW'(velx_r); b_op = $signed({1'b0, dt_r}); end
      MUL_PY: begin a_op = AW'(vely_r); b_op = $signed({1'b0, dt_r}); end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  assign pe = ACCW'(prod_r);
  assign sum_x = ACCW'(posx_r) + pe;
  assign sum_y = ACCW'(posy_r) + pe;
  assign sx = x_r >>> cmd.idx;
  assign sy = y_r >>> cmd.idx;
  assign at = ZW'({2'b00, atan_entry(cmd.idx)});

  assign ang_q = {rel_r, 16'h0000};
  assign ang_h = {ref_yaw_r[15], ref_yaw_r, 15'h0000};
  assign ang = (cmd.op == OP_RINIT_REL) ? ang_q : ang_h;

  assign yaw_w = 16'((z_r[31:0] + 32'h0000_8000) >> 16);
  assign ref_w = ref_valid_r ? ref_yaw_r : yaw_w;
  assign diff = {1'b0, ts_r} - {1'b0, last_r};
  assign ts_le = diff[TSW] || (diff == '0);
  assign ts_over = (|diff[TSW-1:CFGW]) || (diff[CFGW-1:0] > max_r);

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
      ref_yaw_r <= '0;
      time_valid_r <= 1'b0;
      last_r <= '0;
      posx_r <= '0;
      posy_r <= '0;
      max_r <= MAX_INTERVAL_RST;
      mv_r <= 1'b0;
      status_r <= STAT_PUB;
    end else begin
      if (cfg_valid) max_r <= cfg_data;
      mv_r <= (cmd.op == OP_MUL);
      if (cmd.op == OP_LOAD) status_r <= stat.quat_zero ? STAT_INVALID : STAT_PUB;
      if (cmd.op == OP_YAWFIN) begin
        ref_valid_r <= 1'b1;
        ref_yaw_r <= ref_w;
        time_valid_r <= 1'b1;
        last_r <= ts_r;
        if (!time_valid_r) status_r <= STAT_FIRST;
        else if (ts_le || ts_over) status_r <= STAT_RANGE;
        else status_r <= STAT_PUB;
      end
      if (mv_r && status_r == STAT_PUB) begin
        if (msel_r == MUL_PX) begin
          if (sum_x > POS_MAX) posx_r <= POS_MAX[POSW-1:0];
          else if (sum_x < POS_MIN) posx_r <= POS_MIN[POSW-1:0];
          else posx_r <= sum_x[POSW-1:0];
        end
        if (msel_r == MUL_PY) begin
          if (sum_y > POS_MAX) posy_r <= POS_MAX[POSW-1:0];
          else if (sum_y < POS_MIN) posy_r <= POS_MIN[POSW-1:0];
          else posy_r <= sum_y[POSW-1:0];
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      qx_r <= in_tdata[15:0];
      qy_r <= in_tdata[31:16];
      qz_r <= in_tdata[47:32];
      qw_r <= in_tdata[63:48];
      sp_r <= in_tdata[79:64];
      ts_r <= in_tdata[127:80];
    end
    if (cmd.op == OP_MUL) begin
      prod_r <= a_op * b_op;
      msel_r <= cmd.idx;
    end
    if (mv_r) begin
      unique case (msel_r)
        MUL_WW, MUL_XY, MUL_OX_A, MUL_OY_A, MUL_OZ_A, MUL_OW_A: acc_r <= pe;
        MUL_XX: acc_r <= acc_r + pe;
        MUL_YY: acc_r <= acc_r - pe;
        MUL_ZZ: cx_r <= CW'(acc_r - pe);
        MUL_WZ: cy_r <= CW'((acc_r + pe) <<< 1);
        MUL_VX: velx_r <= rnd16(pe);
        MUL_VY: vely_r <= rnd16(pe);
        MUL_OX_B: oqx_r <= rnd16(acc_r + pe);
        MUL_OY_B: oqy_r <= rnd16(acc_r - pe);
        MUL_OZ_B: oqz_r <= rnd16(acc_r - pe);
        MUL_OW_B: oqw_r <= rnd16(acc_r + pe);
        default: acc_r <= acc_r;
      endcase
    end
    unique case (cmd.op)
      OP_VINIT: begin
        if (cx_r < 0) begin
          x_r <= -cx_r;
          y_r <= -cy_r;
          z_r <= ZW'(34'h0_8000_0000);
        end else begin
          x_r <= cx_r;
          y_r <= cy_r;
          z_r <= '0;
        end
      end
      OP_VITER: begin
        if (y_r > 0) begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - at;
        end
      end
      OP_YAWFIN: begin
        rel_r <= yaw_w - ref_w;
        dt_r <= diff[CFGW-1:0];
      end
      OP_RINIT_REL, OP_RINIT_REF: begin
        y_r <= '0;
        if (ang[31] != ang[30]) begin
          x_r <= -KINV;
          z_r <= ZW'($signed(ang + 32'h8000_0000));
        end else begin
          x_r <= KINV;
          z_r <= ZW'($signed(ang));
        end
      end
      OP_RITER: begin
        if (z_r >= 0) begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + at;
        end
      end
      OP_RFIN_REL: begin
        c_r <= AW'(x_r);
        s_r <= AW'(y_r);
      end
      OP_RFIN_REF: begin
        hc_r <= AW'(x_r);
        hs_r <= AW'(y_r);
      end
      OP_PUB: begin
        if (status_r == STAT_INVALID) out_r <= {{(OUT_W-2){1'b0}}, status_r};
        else out_r <= {6'b0, oqw_r, oqz_r, oqy_r, oqx_r, vely_r, velx_r,
                       posy_r, posx_r, status_r};
      end
      default: out_r <= out_r;
    endcase
  end

  assign out_tdata = out_r;

endmodule

### design/imu_heading_odometry_integrator.sv
// channel | ports                                 | beat contents (lsb first)
// in      | in_tvalid in_tready in_tdata[127:0]   | quat x,y,z,w, speed, timestamp
// out     | out_tvalid out_tready out_tdata[199:0]| status, pos x/y, vel x/y, quat x,y,z,w
// cfg     | cfg_valid cfg_ready cfg_data[23:0]    | max interval in us
//
// one item at a time: a valid quaternion takes 6 yaw products, one vectoring and two
// rotating 16-step cordic passes, 12 products and setup steps; a zero one goes straight
// to publish, which waits while an earlier result is held; the next beat is taken as
// the result turns valid; the shared 34x25 multiplier and iterative cordic set the pace
// rst_n synchronous: clears reference, time and position state, interval 1000000
// a finished result waits in the output register while the next beat is accepted
module imu_heading_odometry_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // quat_x, quat_y, quat_z, quat_w, speed, timestamp
  input  logic [imuodo_pkg::IN_W-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status, pos_x, pos_y, vel_x, vel_y, out_quat_x, out_quat_y, out_quat_z,
  // out_quat_w, zero pad
  output logic [imuodo_pkg::OUT_W-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imuodo_pkg::CFGW-1:0]   cfg_data
);
  import imuodo_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register write always taken
  assign cfg_ready = 1'b1;

  // sequencer: walks products, cordic passes and publish
  imuodo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // arithmetic, odometry state and result register
  imuodo_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### sim/imu_heading_odometry_integrator_test.sv
`timescale 1ns / 1ps

module imu_heading_odometry_integrator_test;
  import imuodo_pkg::*;

  localparam int CLK_HALF = 5;
  localparam longint CYCLE_LIMIT = 3000000;
  // arctangent table in binary angle units, 2^32 per turn
  localparam longint ATAN_TURN32[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam longint INV_GAIN_Q30 = 652032874;
  localparam longint POS_TOP = 64'sd140737488355327;
  localparam longint POS_BOTTOM = -64'sd140737488355328;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw, speed;
    logic [47:0]        stamp;
  } odo_sample_t;

  typedef struct {
    status_t            status;
    logic signed [47:0] pos_x, pos_y;
    logic signed [15:0] vel_x, vel_y, oqx, oqy, oqz, oqw;
  } odo_report_t;

  // dead-reckoning predictor plus queue of pending reports
  class odometry_board;
    bit          heading_locked;
    logic [15:0] heading_zero;
    bit          stamp_seen;
    logic [47:0] prev_stamp;
    longint      east_nm, north_nm;
    logic [23:0] step_limit_us;
    odo_report_t pending[$];
    int          mismatches;
    int          checked;
    int          status_count[4];

    function void clear();
      heading_locked = 0;
      heading_zero = '0;
      stamp_seen = 0;
      prev_stamp = '0;
      east_nm = 0;
      north_nm = 0;
      step_limit_us = MAX_INTERVAL_RST;
      pending.delete();
    endfunction

    function logic [15:0] yaw_of(longint qx, longint qy, longint qz, longint qw);
      longint ex, ey, sx, sy;
      logic [31:0] ang;
      ey = 2 * (qx * qy + qw * qz);
      ex = qw * qw + qx * qx - qy * qy - qz * qz;
      ang = '0;
      if (ex < 0) begin
        ex = -ex;
        ey = -ey;
        ang = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        sy = ey >>> i;
        sx = ex >>> i;
        if (ey > 0) begin
          ex += sy; ey -= sx; ang += 32'(ATAN_TURN32[i]);
        end else begin
          ex -= sy; ey += sx; ang -= 32'(ATAN_TURN32[i]);
        end
      end
      ang = ang + 32'h8000;
      return ang[31:16];
    endfunction

    // rotating cordic: cosine and sine in q1.30
    function void cos_sin(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, sx, sy;
      logic [31:0] quad;
      x = INV_GAIN_Q30;
      y = 0;
      quad = ang + 32'h4000_0000;
      if (quad[31]) begin
        x = -x;
        ang = ang + 32'h8000_0000;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        sy = y >>> i;
        sx = x >>> i;
        if (z >= 0) begin
          x -= sy; y += sx; z -= ATAN_TURN32[i];
        end else begin
          x += sy; y -= sx; z += ATAN_TURN32[i];
        end
      end
      c = x;
      s = y;
    endfunction

    function logic signed [15:0] round_sat(longint p);
      longint t;
      t = (p + (longint'(1) <<< 29)) >>> 30;
      if (t > 32767) return 16'sh7fff;
      if (t < -32768) return 16'sh8000;
      return 16'(t);
    endfunction

    function longint clamp48(longint v);
      return v > POS_TOP ? POS_TOP : (v < POS_BOTTOM ? POS_BOTTOM : v);
    endfunction

    function void note_sample(odo_sample_t smp);
      odo_report_t r;
      longint qx, qy, qz, qw, sp, c, s, hc, hs, dt;
      logic [15:0] yaw, rel;
      logic [31:0] half_ref;
      qx = smp.qx; qy = smp.qy; qz = smp.qz; qw = smp.qw; sp = smp.speed;
      r = '{status: STAT_INVALID, default: '0};
      if (qx == 0 && qy == 0 && qz == 0 && qw == 0) begin
        pending.push_back(r);
        return;
      end
      yaw = yaw_of(qx, qy, qz, qw);
      if (!heading_locked) begin
        heading_zero = yaw;
        heading_locked = 1;
      end
      rel = yaw - heading_zero;
      cos_sin({rel, 16'h0}, c, s);
      r.vel_x = round_sat(c * sp);
      r.vel_y = round_sat(s * sp);
      // z rotation by minus half the reference yaw
      half_ref = 32'(longint'($signed(heading_zero)) * 32768);
      cos_sin(half_ref, hc, hs);
      if (!stamp_seen) begin
        r.status = STAT_FIRST;
        stamp_seen = 1;
      end else if (smp.stamp <= prev_stamp ||
                   smp.stamp - prev_stamp > {24'h0, step_limit_us}) begin
        r.status = STAT_RANGE;
      end else begin
        dt = longint'(smp.stamp - prev_stamp);
        east_nm = clamp48(east_nm + longint'(r.vel_x) * dt);
        north_nm = clamp48(north_nm + longint'(r.vel_y) * dt);
        r.status = STAT_PUB;
      end
      prev_stamp = smp.stamp;
      r.pos_x = 48'(east_nm);
      r.pos_y = 48'(north_nm);
      r.oqx = round_sat(hc * qx + hs * qy);
      r.oqy = round_sat(hc * qy - hs * qx);
      r.oqz = round_sat(hc * qz - hs * qw);
      r.oqw = round_sat(hc * qw + hs * qz);
      pending.push_back(r);
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_report(logic [OUT_W-1:0] d);
      odo_report_t e;
      if (pending.size() == 0) begin
        $error("report beat with nothing outstanding: %h", d);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      status_count[e.status]++;
      field("status", e.status, d[1:0]);
      field("pos_x", e.pos_x, $signed(d[49:2]));
      field("pos_y", e.pos_y, $signed(d[97:50]));
      field("vel_x", e.vel_x, $signed(d[113:98]));
      field("vel_y", e.vel_y, $signed(d[129:114]));
      field("out_quat_x", e.oqx, $signed(d[145:130]));
      field("out_quat_y", e.oqy, $signed(d[161:146]));
      field("out_quat_z", e.oqz, $signed(d[177:162]));
      field("out_quat_w", e.oqw, $signed(d[193:178]));
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  // quat_x, quat_y, quat_z, quat_w, speed, timestamp
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 0;
  // status, pos_x, pos_y, vel_x, vel_y, out_quat_x, out_quat_y, out_quat_z,
  // out_quat_w, zero pad
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [CFGW-1:0]   cfg_data = '0;

  odometry_board board;
  bit            steady;        // no idling on either side while set
  longint        cycles;
  logic [47:0]   clock_us;      // running timestamp for generated beats
  int            sent;

  imu_heading_odometry_integrator dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #CLK_HALF clk = 1;
    #CLK_HALF clk = 0;
  end

  // result side: random stalls, checker sees pre-edge values
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= steady || ($urandom_range(99) >= 31);
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(odo_sample_t smp);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {smp.stamp, smp.speed, smp.qw, smp.qz, smp.qy, smp.qx};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    board.note_sample(smp);
    sent++;
  endtask

  // let the pipeline empty before touching the register
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    board.step_limit_us = v;
  endtask

  function automatic odo_sample_t make_sample(bit pure_yaw, logic signed [15:0] sp);
    odo_sample_t s;
    real a;
    int pick;
    pick = $urandom_range(99);
    if (pure_yaw) begin
      a = ($urandom_range(65535) / 65536.0) * 6.283185307;
      s.qw = 16'($rtoi(16384.0 * $cos(a)));
      s.qz = 16'($rtoi(16384.0 * $sin(a)));
      s.qx = 16'($urandom_range(400)) - 16'sd200;
      s.qy = 16'($urandom_range(400)) - 16'sd200;
    end else if (pick < 4) begin
      s.qx = '0; s.qy = '0; s.qz = '0; s.qw = '0;
    end else if (pick < 10) begin
      // full-width values beyond q1.14
      s.qx = 16'($urandom); s.qy = 16'($urandom);
      s.qz = 16'($urandom); s.qw = 16'($urandom);
    end else begin
      s.qx = 16'($urandom_range(32768)) - 16'sd16384;
      s.qy = 16'($urandom_range(32768)) - 16'sd16384;
      s.qz = 16'($urandom_range(32768)) - 16'sd16384;
      s.qw = 16'($urandom_range(32768)) - 16'sd16384;
    end
    s.speed = sp;
    pick = $urandom_range(99);
    if (board.step_limit_us == 0 || pick < 5) begin
      clock_us = clock_us + 48'($urandom_range(5000));
    end else if (pick < 10) begin
      // repeated or backward stamp
      clock_us = clock_us - 48'($urandom_range(3000));
    end else if (pick < 17) begin
      clock_us = clock_us + board.step_limit_us + 48'($urandom_range(1, 9999));
    end else if (pick < 19) begin
      clock_us = 48'({$urandom, $urandom});
    end else begin
      clock_us = clock_us + 48'($urandom_range(board.step_limit_us, 1));
    end
    s.stamp = clock_us;
    return s;
  endfunction

  task automatic random_phase(int n);
    odo_sample_t s;
    for (int i = 0; i < n; i++) begin
      s = make_sample($urandom_range(99) < 40, 16'($urandom));
      if ($urandom_range(9) == 0) s.speed = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      send_sample(s);
    end
  endtask

  initial begin
    odo_sample_t s;
    board = new();
    board.clear();
    cycles = 0;
    steady = 0;
    sent = 0;
    clock_us = 48'd1000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero quaternion before anything, first stamp, extremes
    s = '{qx: 0, qy: 0, qz: 0, qw: 0, speed: 16'sd100, stamp: 48'd50};
    send_sample(s);
    s = '{qx: 0, qy: 0, qz: 16'sd11585, qw: 16'sd11585, speed: 16'sh7fff, stamp: 48'd100};
    send_sample(s);
    s = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, speed: 16'sh7fff, stamp: 48'd200};
    send_sample(s);
    s = '{qx: 0, qy: 0, qz: 16'sd16384, qw: 0, speed: 16'sh8000, stamp: 48'd1000200};
    send_sample(s);
    s = '{qx: 0, qy: 0, qz: 16'sd16384, qw: 0, speed: 16'sd5, stamp: 48'd1000201};
    send_sample(s);
    // step just above the limit, then a repeated stamp
    s = '{qx: 16'sd16384, qy: 0, qz: 0, qw: 0, speed: 16'sd1, stamp: 48'd2000202};
    send_sample(s);
    send_sample(s);
    s = '{qx: -16'sd16384, qy: -16'sd16384, qz: -16'sd16384, qw: -16'sd16384,
          speed: -16'sd1, stamp: 48'd2000300};
    send_sample(s);
    // yaw vector on the x axis: the atan2 y operand is zero
    s = '{qx: 16'sd16384, qy: 0, qz: 0, qw: 16'sd16384, speed: 0, stamp: 48'd2000400};
    send_sample(s);
    s = '{qx: 0, qy: 16'sd16384, qz: 16'sd16384, qw: 0, speed: 16'sd300,
          stamp: 48'd2000500};
    send_sample(s);
    s = '{qx: 16'sh7fff, qy: 16'sh8000, qz: 16'sh7fff, qw: 16'sh8000,
          speed: 16'sh7fff, stamp: 48'hffff_ffff_ffff};
    send_sample(s);
    s = '{qx: -1, qy: -1, qz: -1, qw: -1, speed: -1, stamp: 48'd0};
    send_sample(s);
    s = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, speed: 16'sd10, stamp: 48'd10};
    send_sample(s);
    clock_us = 48'd10;

    // widest step at full speed: drives an accumulator into saturation
    write_limit(24'hffffff);
    for (int i = 0; i < 270; i++) begin
      clock_us = clock_us + 48'hffffff;
      s = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, speed: 16'sh7fff, stamp: clock_us};
      send_sample(s);
    end
    random_phase(60);

    // narrowest step, then zero limit where every step is out of range
    write_limit(24'd1);
    random_phase(40);
    write_limit(24'd0);
    random_phase(30);

    // long stretch with no idling
    write_limit(24'(MAX_INTERVAL_RST));
    steady = 1;
    random_phase(120);
    steady = 0;

    write_limit(24'($urandom_range(100, 50000)));
    random_phase(80);
    write_limit(24'($urandom_range(1, 24'hffffff)));
    random_phase(80);

    drain();
    $display("%0d beats sent, %0d reports checked: published %0d, invalid %0d,",
             sent, board.checked, board.status_count[0], board.status_count[1]);
    $display("first-stamp %0d, out-of-range %0d; limit swept 0, 1, 1000000, max",
             board.status_count[2], board.status_count[3]);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/imuodo_pkg.sv
design/imuodo_ctrl.sv
design/imuodo_dp.sv
design/imu_heading_odometry_integrator.sv
sim/imu_heading_odometry_integrator_test.sv
